### sv/lkvt_pkg.sv
package lkvt_pkg;

  // default sizes of the table
  localparam int DEPTH_DEFAULT       = 16;
  localparam int KEY_WIDTH_DEFAULT   = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // fixed widths of the channel fields
  localparam int KIND_W      = 2;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // control part of a lookup probe travelling down the row of cells
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              hit;
  } probe_ctl_t;

  // end-of-operation update broadcast to every cell
  typedef struct packed {
    logic append;
    logic shift;
  } commit_t;

endpackage

### sv/lkvt_if.sv
interface lkvt_req_if;
  import lkvt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] new_value;

  modport source (output valid, output kind, output key, output new_value, input ready);
  modport sink   (input valid, input kind, input key, input new_value, output ready);
endinterface

interface lkvt_rsp_if;
  import lkvt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     read_value;
  logic                   found;
  logic                   dropped;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output read_value, output found, output dropped,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input found, input dropped,
                  input entry_count, output ready);
endinterface

### sv/lkvt_cell.sv
module lkvt_cell #(
  parameter int INDEX       = 0,
  parameter int DEPTH       = lkvt_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkvt_pkg::probe_ctl_t              ctl_in,
  input  logic [KEY_WIDTH-1:0]              probe_key_in,
  input  logic [VALUE_WIDTH-1:0]            probe_value_in,
  input  logic [$clog2(DEPTH)-1:0]          slot_in,
  input  logic [VALUE_WIDTH-1:0]            rdata_in,
  output lkvt_pkg::probe_ctl_t              ctl_out,
  output logic [KEY_WIDTH-1:0]              probe_key_out,
  output logic [VALUE_WIDTH-1:0]            probe_value_out,
  output logic [$clog2(DEPTH)-1:0]          slot_out,
  output logic [VALUE_WIDTH-1:0]            rdata_out,
  input  logic [$clog2(DEPTH+1)-1:0]        count,
  input  lkvt_pkg::commit_t                 commit,
  input  logic [$clog2(DEPTH)-1:0]          commit_slot,
  input  logic [KEY_WIDTH-1:0]              commit_key,
  input  logic [VALUE_WIDTH-1:0]            commit_value,
  input  logic [KEY_WIDTH-1:0]              upper_key,
  input  logic [VALUE_WIDTH-1:0]            upper_value,
  output logic [KEY_WIDTH-1:0]              key,
  output logic [VALUE_WIDTH-1:0]            value
);
  import lkvt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] MY_SLOT  = IW'(INDEX);
  localparam logic [CW-1:0] MY_COUNT = CW'(INDEX);
  localparam bit HAS_UPPER = (INDEX < DEPTH - 1);

  logic live;
  logic match;

  assign live  = MY_COUNT < count;
  assign match = ctl_in.valid && !ctl_in.hit && live && (probe_key_in == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.kind  <= ctl_in.kind;
      ctl_out.hit   <= ctl_in.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    probe_key_out   <= probe_key_in;
    probe_value_out <= probe_value_in;
    slot_out        <= match ? MY_SLOT : slot_in;
    rdata_out       <= match ? value : rdata_in;
  end

  // entry storage: update in passing, append at the tail, or pull down from above
  always_ff @(posedge clk) begin
    if (match && ctl_in.kind == KIND_SET) begin
      value <= probe_value_in;
    end else if (commit.append && count == MY_COUNT) begin
      key   <= commit_key;
      value <= commit_value;
    end else if (commit.shift && HAS_UPPER && MY_SLOT >= commit_slot) begin
      key   <= upper_key;
      value <= upper_value;
    end
  end

endmodule

### sv/linear_key_value_table_unit.sv
// key-value table searched in order, built as a row of DEPTH cells
//
// channels: req carries kind (set, get, remove), key and new_value; rsp returns
// read_value, found, dropped and entry_count, one word per request word
// a request enters the head of the row and its probe moves one cell per
// cycle; the cell holding a matching key flags the hit, returns its value and,
// for a set, takes the new value as the probe passes
// after the last cell the controller appends the key of a missed set at the
// tail while there is room, or for a remove pulls every entry above the
// matched slot down by one, and updates the entry count; a request passes
// the launch register, each cell, the result and rsp registers; one request
// at a time: a new word is taken once the previous is in the rsp register
// a finished word waits in the rsp register while the receiver stalls; the
// next request is still taken and scanned, but its update and result wait
// until the rsp register is free
// reset clears the entry count and all control state; the entry storage is
// not cleared and is never read above the count
module linear_key_value_table_unit #(
  parameter int DEPTH       = lkvt_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  lkvt_req_if.sink   req,
  lkvt_rsp_if.source rsp
);
  import lkvt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;

  // entry count
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // head of the row: one-cycle probe launch
  probe_ctl_t              launch_ctl;
  logic [KEY_WIDTH-1:0]    launch_key;
  logic [VALUE_WIDTH-1:0]  launch_value;

  // probe chain between cells, element i feeds cell i
  probe_ctl_t              ctl_chain   [DEPTH+1];
  logic [KEY_WIDTH-1:0]    pkey_chain  [DEPTH+1];
  logic [VALUE_WIDTH-1:0]  pval_chain  [DEPTH+1];
  logic [IW-1:0]           slot_chain  [DEPTH+1];
  logic [VALUE_WIDTH-1:0]  rdata_chain [DEPTH+1];

  // stored entries as seen by the neighbor below
  logic [KEY_WIDTH-1:0]    cell_key   [DEPTH];
  logic [VALUE_WIDTH-1:0]  cell_value [DEPTH];

  // probe result captured at the tail of the row
  logic [KIND_W-1:0]       done_kind;
  logic                    done_hit;
  logic [IW-1:0]           done_slot;
  logic [VALUE_WIDTH-1:0]  done_rdata;
  logic [KEY_WIDTH-1:0]    done_key;
  logic [VALUE_WIDTH-1:0]  done_value;

  logic                    rsp_valid;
  logic [VALUE_W-1:0]      rsp_read_value;
  logic                    rsp_found;
  logic                    rsp_dropped;
  logic [COUNT_OUT_W-1:0]  rsp_entry_count;

  logic    out_free;
  logic    finish;
  logic    is_set;
  logic    is_get;
  logic    is_remove;
  commit_t commit;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.read_value  = rsp_read_value;
  assign rsp.found       = rsp_found;
  assign rsp.dropped     = rsp_dropped;
  assign rsp.entry_count = rsp_entry_count;

  assign out_free  = !rsp_valid || rsp.ready;
  assign finish    = (state == ST_COMMIT) && out_free;
  assign is_set    = (done_kind == KIND_SET);
  assign is_get    = (done_kind == KIND_GET);
  assign is_remove = (done_kind == KIND_REMOVE);

  // append a new key when there is room, close the gap after a removal
  assign commit.append = finish && is_set && !done_hit && (count < FULL);
  assign commit.shift  = finish && is_remove && done_hit;

  always_comb begin
    count_next = count;
    if (commit.append) begin
      count_next = count + CW'(1);
    end else if (commit.shift) begin
      count_next = count - CW'(1);
    end
  end

  assign ctl_chain[0]   = launch_ctl;
  assign pkey_chain[0]  = launch_key;
  assign pval_chain[0]  = launch_value;
  assign slot_chain[0]  = '0;
  assign rdata_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   upper_key;
    logic [VALUE_WIDTH-1:0] upper_value;

    if (i < DEPTH - 1) begin : g_upper
      assign upper_key   = cell_key[i+1];
      assign upper_value = cell_value[i+1];
    end else begin : g_top
      // top cell never pulls down
      assign upper_key   = '0;
      assign upper_value = '0;
    end

    lkvt_cell #(
      .INDEX       (i),
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl_in          (ctl_chain[i]),
      .probe_key_in    (pkey_chain[i]),
      .probe_value_in  (pval_chain[i]),
      .slot_in         (slot_chain[i]),
      .rdata_in        (rdata_chain[i]),
      .ctl_out         (ctl_chain[i+1]),
      .probe_key_out   (pkey_chain[i+1]),
      .probe_value_out (pval_chain[i+1]),
      .slot_out        (slot_chain[i+1]),
      .rdata_out       (rdata_chain[i+1]),
      .count           (count),
      .commit          (commit),
      .commit_slot     (done_slot),
      .commit_key      (done_key),
      .commit_value    (done_value),
      .upper_key       (upper_key),
      .upper_value     (upper_value),
      .key             (cell_key[i]),
      .value           (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      launch_ctl <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      launch_ctl.valid <= 1'b0;
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            launch_ctl.valid <= 1'b1;
            launch_ctl.kind  <= req.kind;
            launch_ctl.hit   <= 1'b0;
            launch_key       <= KEY_WIDTH'(req.key);
            launch_value     <= VALUE_WIDTH'(req.new_value);
            state            <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // probe leaves the last cell
          if (ctl_chain[DEPTH].valid) begin
            done_kind  <= ctl_chain[DEPTH].kind;
            done_hit   <= ctl_chain[DEPTH].hit;
            done_slot  <= slot_chain[DEPTH];
            done_rdata <= rdata_chain[DEPTH];
            done_key   <= pkey_chain[DEPTH];
            done_value <= pval_chain[DEPTH];
            state      <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            count           <= count_next;
            rsp_valid       <= 1'b1;
            rsp_read_value  <= (is_get && done_hit) ? VALUE_W'(done_rdata) : '0;
            rsp_found       <= done_hit && (is_set || is_get || is_remove);
            rsp_dropped     <= is_set && !done_hit && (count == FULL);
            rsp_entry_count <= COUNT_OUT_W'(count_next);
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/tb_linear_key_value_table_unit.sv
module tb_linear_key_value_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEFAULT;
  // kind code that the block treats as a no-op
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1100;
  localparam int KEY_POOL_SIZE = 20;
  localparam int LONG_STALL_CYCLES = 400;
  localparam longint LIMIT_CYCLES = 800000;

  // one response word as it appears on the rsp channel
  typedef struct packed {
    logic [VALUE_W-1:0]     read_value;
    logic                   found;
    logic                   dropped;
    logic [COUNT_OUT_W-1:0] entry_count;
  } table_reply_t;

  // mirror of the table contents plus the replies still owed by the block
  class kv_table_mirror;
    logic [KEY_W-1:0]   keys[TABLE_DEPTH];
    logic [VALUE_W-1:0] values[TABLE_DEPTH];
    int unsigned        used;
    table_reply_t       owed_replies[$];
    int unsigned        mismatches;
    int unsigned        replies_checked;
    int unsigned        hits;
    int unsigned        refused_sets;
    int unsigned        kind_seen[4];
    int unsigned        full_visits;

    function new();
      used = 0;
      mismatches = 0;
      replies_checked = 0;
      hits = 0;
      refused_sets = 0;
      full_visits = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    // first slot below the fill level that holds the key, or -1
    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < used; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    // apply one accepted request word and queue the reply it must produce
    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value);
      table_reply_t reply;
      int           slot;
      reply = '0;
      slot = find_slot(key);
      kind_seen[kind]++;
      case (kind)
        KIND_SET: begin
          if (slot >= 0) begin
            values[slot] = value;
            reply.found = 1'b1;
          end else if (used < TABLE_DEPTH) begin
            keys[used] = key;
            values[used] = value;
            used++;
            if (used == TABLE_DEPTH) full_visits++;
          end else begin
            reply.dropped = 1'b1;
            refused_sets++;
          end
        end
        KIND_GET: begin
          if (slot >= 0) begin
            reply.read_value = values[slot];
            reply.found = 1'b1;
          end
        end
        KIND_REMOVE: begin
          // last entry fills the hole
          if (slot >= 0) begin
            keys[slot] = keys[used-1];
            values[slot] = values[used-1];
            used--;
            reply.found = 1'b1;
          end
        end
        default: ;
      endcase
      if (reply.found) hits++;
      reply.entry_count = used[COUNT_OUT_W-1:0];
      owed_replies.push_back(reply);
    endfunction

    // one line per mismatch, and every one is counted
    task report_mismatch(string what);
      mismatches++;
      $display("mismatch @%0t: %s", $time, what);
    endtask

    task check_reply(table_reply_t got);
      table_reply_t want;
      replies_checked++;
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing outstanding: %p", got));
      end else begin
        want = owed_replies.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", got.read_value,
                                    want.read_value));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %b, want %b", got.dropped, want.dropped));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", got.entry_count,
                                    want.entry_count));
      end
    endtask

    task flush_leftovers();
      while (owed_replies.size() > 0) begin
        report_mismatch($sformatf("reply never arrived: %p", owed_replies.pop_front()));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  lkvt_req_if req_ch ();
  lkvt_rsp_if rsp_ch ();

  linear_key_value_table_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kv_table_mirror mirror = new();

  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
  bit               valid_high;
  int               burst_left;
  int               steady_left;
  // long receiver stall is asked by the stimulus and served by the receiver
  int               stall_asked;
  int               stall_served;
  longint           cycle_count;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog, counts every cycle of the run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d replies still owed", cycle_count,
               mirror.owed_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // every word taken off the rsp channel is checked against the oldest owed reply
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      mirror.check_reply({rsp_ch.read_value, rsp_ch.found, rsp_ch.dropped,
                          rsp_ch.entry_count});
    end
  end

  // receiver: picks a new stall pattern at random intervals, and once holds
  // off for a long stretch so the block backs up into the request side
  initial begin
    int mode;
    int mode_left;
    int tick;
    rsp_ch.ready = 1'b0;
    stall_served = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_served) begin
        stall_served++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;                        // no stalls
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));    // coin flip
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
          default: rsp_ch.ready <= (tick % 7 < 4);        // fixed duty cycle
        endcase
      end
    end
  end

  // lower valid only if it is up, so a step never sees two assignments
  task automatic drop_valid();
    if (valid_high) begin
      req_ch.valid <= 1'b0;
      valid_high = 1'b0;
    end
  endtask

  // offer one request word, wait for it to be taken, then maybe idle a while
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value);
    int gap;
    req_ch.valid <= 1'b1;
    valid_high = 1'b1;
    req_ch.kind <= kind;
    req_ch.key <= key;
    req_ch.new_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    mirror.note_request(kind, key, value);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // bursts of random length; now and then a long stretch with no gaps
      if (steady_left > 0) begin
        steady_left--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 28);
        if ($urandom_range(0, 7) == 0) steady_left = 30;
      end
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // sender pause until the block has answered everything
  task automatic wait_drained();
    drop_valid();
    while (mirror.owed_replies.size() != 0) @(negedge clk);
  endtask

  // keys mostly from a pool a bit larger than the table, so hits, misses and
  // refused sets all come up often
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // kind mix depends on the phase: filling, mixed, draining
  function automatic logic [KIND_W-1:0] pick_kind(int phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return KIND_UNUSED;
    case (phase)
      0: return (roll < 66) ? KIND_SET : (roll < 86) ? KIND_GET : KIND_REMOVE;
      1: return (roll < 38) ? KIND_SET : (roll < 70) ? KIND_GET : KIND_REMOVE;
      default: return (roll < 20) ? KIND_SET : (roll < 48) ? KIND_GET : KIND_REMOVE;
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_SET;
    req_ch.key = '0;
    req_ch.new_value = '0;
    valid_high = 1'b0;
    burst_left = 1;
    steady_left = 0;
    stall_asked = 0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-table misses, extreme keys and values, update in place,
    // unused kind, remove that moves the last entry, then fill to the brim
    send_word(KIND_GET, 32'h0, 32'h0);
    send_word(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_SET, 32'h0, 32'hFFFF_FFFF);
    send_word(KIND_SET, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_SET, 32'h0, 32'h5A5A_A5A5);
    send_word(KIND_GET, 32'h0, 32'hFFFF_FFFF);
    send_word(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_REMOVE, 32'h0, 32'h0);
    send_word(KIND_GET, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      send_word(KIND_SET, 32'h1000_0000 + i, 32'hA000_0000 + i);
    end
    // full table: new key refused, existing key still updated, remove frees a slot
    send_word(KIND_SET, 32'h0, 32'h1234_5678);
    send_word(KIND_SET, 32'hFFFF_FFFF, 32'h8765_4321);
    send_word(KIND_REMOVE, 32'h1000_0003, 32'h0);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // long receiver hold-off while the sender keeps offering words
      if (n == 400) begin
        stall_asked++;
        steady_left = 20;
      end
      if (n % 250 == 249) wait_drained();
      send_word(pick_kind((n / 120) % 3), pick_key(), pick_value());
    end

    wait_drained();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    mirror.flush_leftovers();

    $display("sent %0d words (%0d set, %0d get, %0d remove, %0d unused kind), table full %0d times",
             mirror.kind_seen[0] + mirror.kind_seen[1] + mirror.kind_seen[2] +
             mirror.kind_seen[3], mirror.kind_seen[0], mirror.kind_seen[1],
             mirror.kind_seen[2], mirror.kind_seen[3], mirror.full_visits);
    $display("%0d replies checked, %0d hits, %0d sets refused, %0d mismatches",
             mirror.replies_checked, mirror.hits, mirror.refused_sets, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### linear_key_value_table_unit.f
sv/lkvt_pkg.sv
sv/lkvt_if.sv
sv/lkvt_cell.sv
sv/linear_key_value_table_unit.sv
bench/tb_linear_key_value_table_unit.sv
